### rtl/stack_machine_data_unit_macros.svh
// Assertion macros shared by the checker of the stack machine data unit.
`ifndef STACK_MACHINE_DATA_UNIT_MACROS_SVH
`define STACK_MACHINE_DATA_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMDU_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smdu check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMDU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smdu check failed");

`endif

### rtl/smdu_pkg.sv
// Types and codes shared by the stack machine data unit files.
package smdu_pkg;

    localparam int unsigned DEPTH_MAG_W = 11;
    localparam int unsigned HEAP_WORD_W = 65;

    localparam logic [3:0] CMD_PUSH       = 4'd0;
    localparam logic [3:0] CMD_POP        = 4'd1;
    localparam logic [3:0] CMD_COPY       = 4'd2;
    localparam logic [3:0] CMD_SWAP       = 4'd3;
    localparam logic [3:0] CMD_SLIDE      = 4'd4;
    localparam logic [3:0] CMD_HEAP_STORE = 4'd5;
    localparam logic [3:0] CMD_HEAP_LOAD  = 4'd6;
    localparam logic [3:0] CMD_STORE_VAL  = 4'd7;
    localparam logic [3:0] CMD_CALL       = 4'd8;
    localparam logic [3:0] CMD_RETURN     = 4'd9;

    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_SMALL      = 3'd1;
    localparam logic [2:0] ERR_CALL_EMPTY = 3'd2;
    localparam logic [2:0] ERR_UNDEF      = 3'd3;
    localparam logic [2:0] ERR_RANGE      = 3'd4;
    localparam logic [2:0] ERR_VAL_OVF    = 3'd5;
    localparam logic [2:0] ERR_CALL_OVF   = 3'd6;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [63:0] number;
        logic signed [11:0] depth_n;
        logic [15:0]        ret_addr;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [15:0]        return_target;
        logic [2:0]         error_code;
        logic [10:0]        stack_count;
        logic               values_empty;
        logic               calls_empty;
    } t_out_beat;

endpackage

### rtl/smdu_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module smdu_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/smdu_addr_unit.sv
// Shared stack index subtractor and heap address range check.
module smdu_addr_unit #(
    parameter int unsigned CMP_W     = 12,
    parameter int unsigned HEAP_SIZE = 4096,
    parameter int unsigned HEAP_AW   = 12
) (
    input  logic [CMP_W-1:0]   i_base,
    input  logic [CMP_W-1:0]   i_sub,
    input  logic [63:0]        i_word,
    output logic [CMP_W-1:0]   o_diff,
    output logic               o_heap_ok,
    output logic [HEAP_AW-1:0] o_slot
);

    assign o_diff = i_base - i_sub;

    // A stack word is a heap address only when it is non-negative and in range.
    assign o_heap_ok = !i_word[63] && (i_word < 64'(HEAP_SIZE));
    assign o_slot    = i_word[HEAP_AW-1:0];

endmodule

### rtl/stack_machine_data_unit.sv
// Top level: sequencer over the value, call and heap memories. Each command passes decode,
// the steps P1 to P3 that it needs and a finish state that registers its result beat: none
// for push, call, slide of an empty stack, unknown codes and decode errors; P1 for pop, copy,
// slide, store value, return and heap range errors; P1 and P2 for heap store and heap retrieve;
// P1 to P3 for swap, set by the single port of the value memory. One command in flight;
// finish waits out result stalls. Reset clears the counts, then sweeps the heap valid marks.
module stack_machine_data_unit #(
    parameter int unsigned VALUE_DEPTH = 1024,
    parameter int unsigned CALL_DEPTH  = 256,
    parameter int unsigned HEAP_SIZE   = 4096,
    parameter int unsigned ADDR_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  smdu_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output smdu_pkg::t_out_beat o_out_data
);

    localparam int unsigned V_AW  = $clog2(VALUE_DEPTH);
    localparam int unsigned V_CW  = $clog2(VALUE_DEPTH + 1);
    localparam int unsigned C_AW  = $clog2(CALL_DEPTH);
    localparam int unsigned C_CW  = $clog2(CALL_DEPTH + 1);
    localparam int unsigned H_AW  = $clog2(HEAP_SIZE);
    localparam int unsigned CMP_W =
        (V_CW > smdu_pkg::DEPTH_MAG_W ? V_CW : smdu_pkg::DEPTH_MAG_W) + 1;
    localparam int unsigned RET_W = ADDR_BITS < 16 ? ADDR_BITS : 16;
    localparam logic [15:0] RET_MASK = 16'((32'd1 << RET_W) - 32'd1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_P1   = 3'd3;
    localparam logic [2:0] S_P2   = 3'd4;
    localparam logic [2:0] S_P3   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [V_CW-1:0]     r_vcnt, n_vcnt;
    logic [C_CW-1:0]     r_ccnt, n_ccnt;
    logic [H_AW-1:0]     r_clr, n_clr;
    logic                r_out_valid, n_out_valid;

    smdu_pkg::t_in_beat  r_beat, n_beat;
    smdu_pkg::t_out_beat r_out, n_out;
    logic [2:0]          r_err, n_err;
    logic [63:0]         r_result, n_result;
    logic [15:0]         r_target, n_target;
    logic [63:0]         r_tmp, n_tmp;
    logic [H_AW-1:0]     r_slot, n_slot;
    logic [V_CW-1:0]     r_drop, n_drop;

    logic [CMP_W-1:0]    au_sub, au_diff;
    logic                au_heap_ok;
    logic [H_AW-1:0]     au_slot;

    logic                v_we;
    logic [63:0]         v_wdata, v_rdata;
    logic [V_AW-1:0]     v_idx;
    logic                h_we;
    logic [H_AW-1:0]     h_waddr;
    logic [smdu_pkg::HEAP_WORD_W-1:0] h_wdata, h_rdata;
    logic                c_we;
    logic [C_AW-1:0]     c_raddr;
    logic [15:0]         c_wdata, c_rdata;

    logic                n_neg, n_ge_cnt, v_full, v_empty, v_lt2, c_full, c_empty;
    logic [CMP_W-1:0]    n_mag;
    logic [V_CW-1:0]     below;

    smdu_addr_unit #(
        .CMP_W    (CMP_W),
        .HEAP_SIZE(HEAP_SIZE),
        .HEAP_AW  (H_AW)
    ) u_addr (
        .i_base   (CMP_W'(r_vcnt)),
        .i_sub    (au_sub),
        .i_word   (v_rdata),
        .o_diff   (au_diff),
        .o_heap_ok(au_heap_ok),
        .o_slot   (au_slot)
    );

    smdu_ram #(.WIDTH(64), .DEPTH(VALUE_DEPTH), .AW(V_AW)) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(v_idx),
        .i_wdata(v_wdata),
        .i_raddr(v_idx),
        .o_rdata(v_rdata)
    );

    smdu_ram #(.WIDTH(16), .DEPTH(CALL_DEPTH), .AW(C_AW)) u_call_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(r_ccnt[C_AW-1:0]),
        .i_wdata(c_wdata),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    smdu_ram #(.WIDTH(smdu_pkg::HEAP_WORD_W), .DEPTH(HEAP_SIZE), .AW(H_AW)) u_heap_ram (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_waddr),
        .i_wdata(h_wdata),
        .i_raddr(au_slot),
        .o_rdata(h_rdata)
    );

    assign v_idx   = au_diff[V_AW-1:0];
    assign c_wdata = r_beat.ret_addr & RET_MASK;
    assign c_raddr = C_AW'(r_ccnt - C_CW'(1));

    assign n_neg    = r_beat.depth_n[11];
    assign n_mag    = CMP_W'(r_beat.depth_n[10:0]);
    assign n_ge_cnt = n_mag >= CMP_W'(r_vcnt);
    assign v_full   = r_vcnt == V_CW'(VALUE_DEPTH);
    assign v_empty  = r_vcnt == '0;
    assign v_lt2    = r_vcnt < V_CW'(2);
    assign c_full   = r_ccnt == C_CW'(CALL_DEPTH);
    assign c_empty  = r_ccnt == '0;
    assign below    = r_vcnt - V_CW'(1);

    always_comb begin
        n_state     = r_state;
        n_vcnt      = r_vcnt;
        n_ccnt      = r_ccnt;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_beat      = r_beat;
        n_out       = r_out;
        n_err       = r_err;
        n_result    = r_result;
        n_target    = r_target;
        n_tmp       = r_tmp;
        n_slot      = r_slot;
        n_drop      = r_drop;
        au_sub      = CMP_W'(1);
        v_we        = 1'b0;
        v_wdata     = v_rdata;
        h_we        = 1'b0;
        h_waddr     = au_slot;
        h_wdata     = {1'b1, v_rdata};
        c_we        = 1'b0;

        // A waiting result beat leaves once the far side stops stalling.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                h_we    = 1'b1;
                h_waddr = r_clr;
                h_wdata = '0;
                n_clr   = r_clr + H_AW'(1);
                if (r_clr == H_AW'(HEAP_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_beat   = i_in_data;
                    n_err    = smdu_pkg::ERR_OK;
                    n_result = '0;
                    n_target = '0;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                unique case (r_beat.cmd) inside
                    smdu_pkg::CMD_PUSH: begin
                        au_sub = '0;
                        if (v_full) begin
                            n_err = smdu_pkg::ERR_VAL_OVF;
                        end else begin
                            v_we    = 1'b1;
                            v_wdata = r_beat.number;
                            n_vcnt  = r_vcnt + V_CW'(1);
                        end
                    end
                    smdu_pkg::CMD_POP,
                    smdu_pkg::CMD_HEAP_LOAD,
                    smdu_pkg::CMD_STORE_VAL: begin
                        if (v_empty) begin
                            n_err = smdu_pkg::ERR_SMALL;
                        end else begin
                            n_state = S_P1;
                        end
                    end
                    smdu_pkg::CMD_COPY: begin
                        au_sub = n_mag + CMP_W'(1);
                        if (n_neg || n_ge_cnt) begin
                            n_err = smdu_pkg::ERR_SMALL;
                        end else if (v_full) begin
                            n_err = smdu_pkg::ERR_VAL_OVF;
                        end else begin
                            n_state = S_P1;
                        end
                    end
                    smdu_pkg::CMD_SWAP: begin
                        if (v_lt2) begin
                            n_err = smdu_pkg::ERR_SMALL;
                        end else begin
                            n_state = S_P1;
                        end
                    end
                    smdu_pkg::CMD_SLIDE: begin
                        n_drop = (n_neg || n_ge_cnt) ? below : V_CW'(n_mag);
                        if (!v_empty) begin
                            n_state = S_P1;
                        end
                    end
                    smdu_pkg::CMD_HEAP_STORE: begin
                        au_sub = CMP_W'(2);
                        if (v_lt2) begin
                            n_err = smdu_pkg::ERR_SMALL;
                        end else begin
                            n_state = S_P1;
                        end
                    end
                    smdu_pkg::CMD_CALL: begin
                        if (c_full) begin
                            n_err = smdu_pkg::ERR_CALL_OVF;
                        end else begin
                            c_we   = 1'b1;
                            n_ccnt = r_ccnt + C_CW'(1);
                        end
                    end
                    smdu_pkg::CMD_RETURN: begin
                        if (c_empty) begin
                            n_err = smdu_pkg::ERR_CALL_EMPTY;
                        end else begin
                            n_state = S_P1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_P1: begin
                n_state = S_FIN;
                unique case (r_beat.cmd) inside
                    smdu_pkg::CMD_POP: begin
                        n_result = v_rdata;
                        n_vcnt   = r_vcnt - V_CW'(1);
                    end
                    smdu_pkg::CMD_COPY: begin
                        au_sub = '0;
                        v_we   = 1'b1;
                        n_vcnt = r_vcnt + V_CW'(1);
                    end
                    smdu_pkg::CMD_SWAP: begin
                        au_sub  = CMP_W'(2);
                        n_tmp   = v_rdata;
                        n_state = S_P2;
                    end
                    smdu_pkg::CMD_SLIDE: begin
                        au_sub = CMP_W'(r_drop) + CMP_W'(1);
                        v_we   = 1'b1;
                        n_vcnt = r_vcnt - r_drop;
                    end
                    smdu_pkg::CMD_HEAP_STORE,
                    smdu_pkg::CMD_HEAP_LOAD: begin
                        // Heap store reads the value word next; retrieve reads the heap.
                        if (!au_heap_ok) begin
                            n_err = smdu_pkg::ERR_RANGE;
                        end else begin
                            n_slot  = au_slot;
                            n_state = S_P2;
                        end
                    end
                    smdu_pkg::CMD_STORE_VAL: begin
                        if (!au_heap_ok) begin
                            n_err = smdu_pkg::ERR_RANGE;
                        end else begin
                            h_we    = 1'b1;
                            h_wdata = {1'b1, r_beat.number};
                            n_vcnt  = r_vcnt - V_CW'(1);
                        end
                    end
                    smdu_pkg::CMD_RETURN: begin
                        n_target = c_rdata;
                        n_ccnt   = r_ccnt - C_CW'(1);
                    end
                    default: begin
                    end
                endcase
            end
            S_P2: begin
                n_state = S_FIN;
                unique case (r_beat.cmd)
                    smdu_pkg::CMD_SWAP: begin
                        v_we    = 1'b1;
                        n_state = S_P3;
                    end
                    smdu_pkg::CMD_HEAP_STORE: begin
                        h_we    = 1'b1;
                        h_waddr = r_slot;
                        n_vcnt  = r_vcnt - V_CW'(2);
                    end
                    smdu_pkg::CMD_HEAP_LOAD: begin
                        if (!h_rdata[smdu_pkg::HEAP_WORD_W-1]) begin
                            n_err = smdu_pkg::ERR_UNDEF;
                        end else begin
                            v_we    = 1'b1;
                            v_wdata = h_rdata[63:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_P3: begin
                au_sub  = CMP_W'(2);
                v_we    = 1'b1;
                v_wdata = r_tmp;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.result_value  = r_result;
                    n_out.return_target = r_target;
                    n_out.error_code    = r_err;
                    n_out.stack_count   = 11'(r_vcnt);
                    n_out.values_empty  = v_empty;
                    n_out.calls_empty   = c_empty;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_vcnt      <= '0;
            r_ccnt      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcnt      <= n_vcnt;
            r_ccnt      <= n_ccnt;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat   <= n_beat;
        r_out    <= n_out;
        r_err    <= n_err;
        r_result <= n_result;
        r_target <= n_target;
        r_tmp    <= n_tmp;
        r_slot   <= n_slot;
        r_drop   <= n_drop;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/smdu_chk.sv
// Port-level checker for the stack machine data unit, bound to the top level.
`include "stack_machine_data_unit_macros.svh"

module smdu_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input smdu_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input smdu_pkg::t_out_beat o_out_data
);

    // A stalled result beat stays offered and unchanged.
    `SMDU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // A failed command reports no popped value and no return target.
    `SMDU_ASSERT_NOW(a_err_no_data, o_out_valid && (o_out_data.error_code != smdu_pkg::ERR_OK), (o_out_data.result_value == 64'sd0) && (o_out_data.return_target == 16'd0))

    // An empty value stack always shows a zero count.
    `SMDU_ASSERT_NOW(a_empty_count, o_out_valid && o_out_data.values_empty, o_out_data.stack_count == 11'd0)

    // Right after reset the heap sweep runs, so no beat is taken or offered.
    `SMDU_ASSERT_NOW(a_reset_quiet, !$past(i_rst_n), o_in_stall && !o_out_valid)

endmodule

bind stack_machine_data_unit smdu_chk u_smdu_chk (.*);

### tb/tb_stack_machine_data_unit.sv
// Self-checking testbench for the stack machine data unit with a command-level scoreboard.
module tb_stack_machine_data_unit;

    localparam int VALUE_DEPTH  = 1024;
    localparam int CALL_DEPTH   = 256;
    localparam int HEAP_SIZE    = 4096;
    localparam int ADDR_BITS    = 16;
    localparam int IDLE_PCT     = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = 12;
    localparam int TIMEOUT      = 12 * 600000;

    localparam logic [15:0] RET_MASK = (ADDR_BITS >= 16) ? 16'hFFFF : 16'((1 << ADDR_BITS) - 1);
    localparam logic [3:0]  CMD_FIRST_UNUSED = 4'd10;
    localparam logic [3:0]  CMD_LAST_UNUSED  = 4'd15;
    localparam logic [63:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
    localparam logic [11:0] DROP_ALL = 12'hFFF;

    class smdu_scoreboard;
        logic [63:0] values [VALUE_DEPTH];
        logic [15:0] calls [CALL_DEPTH];
        logic [63:0] heap_words [HEAP_SIZE];
        bit          heap_written [HEAP_SIZE];
        int          vcount;
        int          ccount;
        smdu_pkg::t_out_beat outcome_q [$];
        int          failures;
        int          checked;
        int          commands;
        int          err_seen [8];

        function logic [2:0] heap_check(logic [63:0] w);
            return (w[63] || w >= 64'(HEAP_SIZE)) ? smdu_pkg::ERR_RANGE : smdu_pkg::ERR_OK;
        endfunction

        // Applies one accepted command to the shadow state and queues its outcome.
        function void predict_outcome(smdu_pkg::t_in_beat b);
            smdu_pkg::t_out_beat exp;
            logic [63:0] top;
            logic [2:0]  err;
            int          n;
            int          drop;
            int          slot;
            exp = '0;
            err = smdu_pkg::ERR_OK;
            n = int'($signed(b.depth_n));
            case (b.cmd)
                smdu_pkg::CMD_PUSH: begin
                    if (vcount >= VALUE_DEPTH) err = smdu_pkg::ERR_VAL_OVF;
                    else begin
                        values[vcount] = b.number;
                        vcount++;
                    end
                end
                smdu_pkg::CMD_POP: begin
                    if (vcount == 0) err = smdu_pkg::ERR_SMALL;
                    else begin
                        vcount--;
                        exp.result_value = values[vcount];
                    end
                end
                smdu_pkg::CMD_COPY: begin
                    if (n < 0 || n >= vcount) err = smdu_pkg::ERR_SMALL;
                    else if (vcount >= VALUE_DEPTH) err = smdu_pkg::ERR_VAL_OVF;
                    else begin
                        values[vcount] = values[vcount - 1 - n];
                        vcount++;
                    end
                end
                smdu_pkg::CMD_SWAP: begin
                    if (vcount < 2) err = smdu_pkg::ERR_SMALL;
                    else begin
                        top = values[vcount - 1];
                        values[vcount - 1] = values[vcount - 2];
                        values[vcount - 2] = top;
                    end
                end
                smdu_pkg::CMD_SLIDE: begin
                    // An empty stack makes slide a no-op without an error.
                    if (vcount > 0) begin
                        drop = (n < 0 || n > vcount - 1) ? vcount - 1 : n;
                        top = values[vcount - 1];
                        vcount -= drop;
                        values[vcount - 1] = top;
                    end
                end
                smdu_pkg::CMD_HEAP_STORE: begin
                    if (vcount < 2) err = smdu_pkg::ERR_SMALL;
                    else begin
                        err = heap_check(values[vcount - 2]);
                        if (err == smdu_pkg::ERR_OK) begin
                            slot = int'(values[vcount - 2][31:0]);
                            heap_words[slot] = values[vcount - 1];
                            heap_written[slot] = 1'b1;
                            vcount -= 2;
                        end
                    end
                end
                smdu_pkg::CMD_HEAP_LOAD: begin
                    if (vcount == 0) err = smdu_pkg::ERR_SMALL;
                    else begin
                        // The range check wins over the valid mark.
                        err = heap_check(values[vcount - 1]);
                        if (err == smdu_pkg::ERR_OK) begin
                            slot = int'(values[vcount - 1][31:0]);
                            if (!heap_written[slot]) err = smdu_pkg::ERR_UNDEF;
                            else values[vcount - 1] = heap_words[slot];
                        end
                    end
                end
                smdu_pkg::CMD_STORE_VAL: begin
                    if (vcount == 0) err = smdu_pkg::ERR_SMALL;
                    else begin
                        err = heap_check(values[vcount - 1]);
                        if (err == smdu_pkg::ERR_OK) begin
                            slot = int'(values[vcount - 1][31:0]);
                            heap_words[slot] = b.number;
                            heap_written[slot] = 1'b1;
                            vcount--;
                        end
                    end
                end
                smdu_pkg::CMD_CALL: begin
                    if (ccount >= CALL_DEPTH) err = smdu_pkg::ERR_CALL_OVF;
                    else begin
                        calls[ccount] = b.ret_addr & RET_MASK;
                        ccount++;
                    end
                end
                smdu_pkg::CMD_RETURN: begin
                    if (ccount == 0) err = smdu_pkg::ERR_CALL_EMPTY;
                    else begin
                        ccount--;
                        exp.return_target = calls[ccount];
                    end
                end
                default: ;
            endcase
            exp.error_code   = err;
            exp.stack_count  = 11'(vcount);
            exp.values_empty = (vcount == 0);
            exp.calls_empty  = (ccount == 0);
            err_seen[err]++;
            commands++;
            outcome_q.insert(outcome_q.size(), exp);
        endfunction

        function void check_outcome(smdu_pkg::t_out_beat got);
            smdu_pkg::t_out_beat exp;
            checked++;
            if (outcome_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Result beat %0d arrived with no command waiting", checked);
                return;
            end
            exp = outcome_q.pop_front();
            if (got !== exp) begin
                failures++;
                if (failures <= 10) begin
                    $display("Mismatch on result %0d:", checked);
                    $display("  expected value=%h target=%h err=%0d count=%0d vempty=%b cempty=%b",
                             exp.result_value, exp.return_target, exp.error_code,
                             exp.stack_count, exp.values_empty, exp.calls_empty);
                    $display("  actual   value=%h target=%h err=%0d count=%0d vempty=%b cempty=%b",
                             got.result_value, got.return_target, got.error_code,
                             got.stack_count, got.values_empty, got.calls_empty);
                end
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void close_out();
            if (outcome_q.size() != 0) begin
                failures += outcome_q.size();
                $display("%0d expected results never arrived", outcome_q.size());
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    smdu_pkg::t_in_beat  in_beat   = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    smdu_pkg::t_out_beat out_beat;

    smdu_scoreboard sb;
    bit  quiet      = 1'b0;
    bit  hold_req   = 1'b0;
    int  sent       = 0;
    int  holds_done = 0;
    int  cycles     = 0;
    int  hold_count;

    stack_machine_data_unit #(
        .VALUE_DEPTH(VALUE_DEPTH),
        .CALL_DEPTH (CALL_DEPTH),
        .HEAP_SIZE  (HEAP_SIZE),
        .ADDR_BITS  (ADDR_BITS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_beat)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (rst_n && in_valid && !in_stall) sb.predict_outcome(in_beat);
        if (rst_n && out_valid && !out_stall) sb.check_outcome(out_beat);
    end

    // Result side: random stalls, plus one long hold-off when the command side asks.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
                holds_done++;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("Timeout with %0d results still pending", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

    function automatic smdu_pkg::t_in_beat make_cmd(logic [3:0] code, logic [63:0] num = '0,
                                                    logic [11:0] dn = '0, logic [15:0] ra = '0);
        smdu_pkg::t_in_beat b;
        b.cmd      = code;
        b.number   = num;
        b.depth_n  = dn;
        b.ret_addr = ra;
        return b;
    endfunction

    function automatic logic [63:0] rand_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return WORD_MAX;
        if (pick == 1) return WORD_MIN;
        if (pick == 2) return '0;
        if (pick == 3) return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly a small pool of heap slots, so retrieves find written words.
    function automatic logic [63:0] rand_addr();
        int pick;
        pick = $urandom_range(19);
        if (pick < 14) return 64'($urandom_range(15));
        if (pick == 14) return 64'(HEAP_SIZE - 1);
        if (pick == 15) return 64'($urandom_range(HEAP_SIZE - 1));
        if (pick == 16) return 64'(HEAP_SIZE + $urandom_range(64));
        if (pick == 17) return {1'b1, 31'($urandom), $urandom};
        if (pick == 18) return {1'b0, 31'($urandom), $urandom};
        return '1;
    endfunction

    function automatic smdu_pkg::t_in_beat rand_noise();
        return make_cmd(4'($urandom_range(15)), rand_word(), 12'($urandom), 16'($urandom));
    endfunction

    task automatic send_cmd(input smdu_pkg::t_in_beat b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // Drops valid and waits until every accepted command has its result.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic send_random_single();
        smdu_pkg::t_in_beat b;
        int                 pick;
        b = rand_noise();
        pick = $urandom_range(99);
        if (pick < 20) begin
            b.cmd = smdu_pkg::CMD_PUSH;
            if ($urandom_range(1)) b.number = rand_addr();
        end else if (pick < 33) b.cmd = smdu_pkg::CMD_POP;
        else if (pick < 43) begin
            b.cmd = smdu_pkg::CMD_COPY;
            if ($urandom_range(3) != 0) b.depth_n = 12'($urandom_range(7));
        end else if (pick < 50) b.cmd = smdu_pkg::CMD_SWAP;
        else if (pick < 55) begin
            b.cmd = smdu_pkg::CMD_SLIDE;
            if ($urandom_range(2) == 0) b.depth_n = 12'($urandom_range(3));
            else if ($urandom_range(1)) b.depth_n = DROP_ALL;
        end else if (pick < 59) b.cmd = smdu_pkg::CMD_HEAP_STORE;
        else if (pick < 63) b.cmd = smdu_pkg::CMD_HEAP_LOAD;
        else if (pick < 67) b.cmd = smdu_pkg::CMD_STORE_VAL;
        else if (pick < 78) b.cmd = smdu_pkg::CMD_CALL;
        else if (pick < 89) b.cmd = smdu_pkg::CMD_RETURN;
        else if (pick < 94) b.cmd = 4'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
        send_cmd(b);
    endtask

    task automatic send_heap_sequence();
        int kind;
        kind = $urandom_range(2);
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, rand_addr(), 12'($urandom), 16'($urandom)));
        if (kind == 0) begin
            send_cmd(make_cmd(smdu_pkg::CMD_PUSH, rand_word(), 12'($urandom), 16'($urandom)));
            send_cmd(make_cmd(smdu_pkg::CMD_HEAP_STORE, rand_word(), 12'($urandom),
                              16'($urandom)));
        end else if (kind == 1) begin
            send_cmd(make_cmd(smdu_pkg::CMD_HEAP_LOAD, rand_word(), 12'($urandom),
                              16'($urandom)));
            if ($urandom_range(1))
                send_cmd(make_cmd(smdu_pkg::CMD_POP, rand_word(), 12'($urandom),
                                  16'($urandom)));
        end else begin
            send_cmd(make_cmd(smdu_pkg::CMD_STORE_VAL, rand_word(), 12'($urandom),
                              16'($urandom)));
        end
    endtask

    task automatic send_random(input int count, input bit with_hold);
        int stop_at;
        int hold_at;
        stop_at = sent + count;
        hold_at = sent + count / 3;
        while (sent < stop_at) begin
            if (with_hold && sent >= hold_at) begin
                hold_req = 1'b1;
                with_hold = 1'b0;
            end
            if ($urandom_range(9) < 3) send_heap_sequence();
            else send_random_single();
        end
    endtask

    // Fills the call stack past the brim and drains it past empty, with no idling.
    task automatic fill_calls();
        int i;
        settle();
        quiet = 1'b1;
        for (i = sb.ccount; i < CALL_DEPTH + 3; i++)
            send_cmd(make_cmd(smdu_pkg::CMD_CALL, rand_word(), 12'($urandom), 16'($urandom)));
        for (i = 0; i < CALL_DEPTH + 2; i++)
            send_cmd(make_cmd(smdu_pkg::CMD_RETURN, rand_word(), 12'($urandom), 16'($urandom)));
        quiet = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty-stack cases first, then extremes and the heap corner cases.
        send_cmd(make_cmd(smdu_pkg::CMD_POP));
        send_cmd(make_cmd(smdu_pkg::CMD_SWAP));
        send_cmd(make_cmd(smdu_pkg::CMD_SLIDE, '0, 12'd5));
        send_cmd(make_cmd(smdu_pkg::CMD_HEAP_LOAD));
        send_cmd(make_cmd(smdu_pkg::CMD_STORE_VAL, WORD_MAX));
        send_cmd(make_cmd(smdu_pkg::CMD_HEAP_STORE));
        send_cmd(make_cmd(smdu_pkg::CMD_RETURN));
        send_cmd(make_cmd(smdu_pkg::CMD_CALL, '0, '0, 16'hFFFF));
        send_cmd(make_cmd(smdu_pkg::CMD_CALL, '0, '0, 16'h0000));
        send_cmd(make_cmd(smdu_pkg::CMD_RETURN));
        send_cmd(make_cmd(smdu_pkg::CMD_RETURN));
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, WORD_MAX));
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, WORD_MIN));
        send_cmd(make_cmd(smdu_pkg::CMD_COPY, '0, 12'd1));
        send_cmd(make_cmd(smdu_pkg::CMD_COPY, '0, 12'd3));
        send_cmd(make_cmd(smdu_pkg::CMD_COPY, '0, DROP_ALL));
        send_cmd(make_cmd(smdu_pkg::CMD_SWAP));
        send_cmd(make_cmd(smdu_pkg::CMD_POP));
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, 64'(HEAP_SIZE - 1)));
        send_cmd(make_cmd(smdu_pkg::CMD_HEAP_LOAD));
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, 64'hDEAD_BEEF_0123_4567));
        send_cmd(make_cmd(smdu_pkg::CMD_HEAP_STORE));
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, 64'(HEAP_SIZE - 1)));
        send_cmd(make_cmd(smdu_pkg::CMD_HEAP_LOAD));
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, 64'(HEAP_SIZE)));
        send_cmd(make_cmd(smdu_pkg::CMD_HEAP_LOAD));
        send_cmd(make_cmd(smdu_pkg::CMD_PUSH, '1));
        send_cmd(make_cmd(smdu_pkg::CMD_STORE_VAL, WORD_MIN));
        send_cmd(make_cmd(smdu_pkg::CMD_SLIDE, '0, DROP_ALL));
        send_cmd(make_cmd(CMD_FIRST_UNUSED));
        send_cmd(make_cmd(CMD_LAST_UNUSED, '1, '1, '1));

        send_random(RANDOM_ITEMS / 2, 1'b1);
        fill_calls();
        send_random(RANDOM_ITEMS - RANDOM_ITEMS / 2, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.close_out();

        $display("Ran %0d commands and checked %0d results in %0d cycles, %0d long hold-off(s)",
                 sb.commands, sb.checked, cycles, holds_done);
        $display("ok %0d, underflow %0d, no call %0d, undef %0d, range %0d, call ovf %0d",
                 sb.err_seen[smdu_pkg::ERR_OK], sb.err_seen[smdu_pkg::ERR_SMALL],
                 sb.err_seen[smdu_pkg::ERR_CALL_EMPTY], sb.err_seen[smdu_pkg::ERR_UNDEF],
                 sb.err_seen[smdu_pkg::ERR_RANGE], sb.err_seen[smdu_pkg::ERR_CALL_OVF]);
        if (sb.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures", sb.failures);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/smdu_pkg.sv
rtl/smdu_ram.sv
rtl/smdu_addr_unit.sv
rtl/stack_machine_data_unit.sv
rtl/smdu_chk.sv
tb/tb_stack_machine_data_unit.sv
